// File: hdl/gpg_pkg.sv
// ----------------------------------------------------------------------------
// gpg_pkg
// Types, constants and tables shared by the Gaussian pulse gradient block.
// ----------------------------------------------------------------------------
package gpg_pkg;

    localparam int DATA_W    = 32;
    localparam int ACC_WIDTH = 48;
    localparam int OUT_W     = 48;
    localparam int PROD_W    = 64;
    localparam int SUM_W     = 66;
    localparam int CFG_IDX_W = 2;
    localparam int EXP_W     = 17;

    localparam logic signed [PROD_W-1:0] LOG2E_Q16 = 64'sd94548;
    localparam logic [PROD_W-2:0]        EXP_LIMIT = 63'd786432;
    localparam logic [PROD_W-2:0]        PROD_CAP  = {1'b1, 62'd0};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AMPLITUDE = 2'd0,
        REG_WIDTH     = 2'd1,
        REG_CENTER    = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_EXP,
        ST_ACC
    } state_t;

    typedef enum logic [3:0] {
        OP_D2, OP_S2, OP_X, OP_Y, OP_E, OP_P, OP_W1, OP_W2, OP_C1, OP_C2
    } op_t;

    typedef struct packed {
        logic load;
        logic mul_start;
        logic wr_en;
        logic exp_en;
        logic acc_en;
        op_t  op;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic last;
        logic out_full;
    } dp_sts_t;

    function automatic op_t next_op(input op_t op);
        op_t nxt;
        unique case (op)
            OP_D2:   nxt = OP_S2;
            OP_S2:   nxt = OP_X;
            OP_X:    nxt = OP_Y;
            OP_Y:    nxt = OP_E;
            OP_E:    nxt = OP_P;
            OP_P:    nxt = OP_W1;
            OP_W1:   nxt = OP_W2;
            OP_W2:   nxt = OP_C1;
            OP_C1:   nxt = OP_C2;
            default: nxt = OP_D2;
        endcase
        return nxt;
    endfunction

    // 2^(-k/16) in unsigned Q1.16
    function automatic logic [EXP_W-1:0] pow2_tab(input logic [4:0] k);
        logic [EXP_W-1:0] v;
        case (k)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/gpg_if.sv
// ----------------------------------------------------------------------------
// gpg_if
// Request channels for samples in and gradient results out.
// ----------------------------------------------------------------------------
interface gpg_in_if;
    import gpg_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] sample_time;
    logic signed [DATA_W-1:0] time_gradient;
    logic                     last_sample;

    modport source (output valid, sample_time, time_gradient, last_sample, input ready);
    modport sink   (input valid, sample_time, time_gradient, last_sample, output ready);
endinterface

interface gpg_out_if;
    import gpg_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] grad_amplitude;
    logic signed [OUT_W-1:0] grad_width;
    logic signed [OUT_W-1:0] grad_center;
    logic                    saturated;

    modport source (output valid, grad_amplitude, grad_width, grad_center, saturated,
                    input ready);
    modport sink   (input valid, grad_amplitude, grad_width, grad_center, saturated,
                    output ready);
endinterface

// File: hdl/gpg_mul.sv
// ----------------------------------------------------------------------------
// gpg_mul
// Iterative signed Q16.16 multiplier: four 32x32 partial products, then
// truncate toward zero and clamp the magnitude at 2^62.
// ----------------------------------------------------------------------------
module gpg_mul
    import gpg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [PROD_W-1:0] op_a,
    input  logic signed [PROD_W-1:0] op_b,
    output logic                     done,
    output logic signed [PROD_W-1:0] result,
    output logic                     sat
);

    logic [PROD_W-1:0]   mag_a_reg, mag_b_reg;
    logic                neg_reg;
    logic [1:0]          cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [2*PROD_W-1:0] prod_reg;

    logic [31:0]         half_a, half_b;
    logic [63:0]         pp;
    logic [6:0]          shamt;
    logic [PROD_W-2:0]   mag;

    always_comb
    begin
        half_a = cnt_reg[0] ? mag_a_reg[63:32] : mag_a_reg[31:0];
        half_b = cnt_reg[1] ? mag_b_reg[63:32] : mag_b_reg[31:0];
        pp     = 64'(half_a) * 64'(half_b);
        shamt  = {cnt_reg[0] & cnt_reg[1], cnt_reg[0] ^ cnt_reg[1], 5'd0};
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 2'd0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == 2'd3)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 2'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_a_reg <= op_a[PROD_W-1] ? PROD_W'(-op_a) : PROD_W'(op_a);
            mag_b_reg <= op_b[PROD_W-1] ? PROD_W'(-op_b) : PROD_W'(op_b);
            neg_reg   <= op_a[PROD_W-1] ^ op_b[PROD_W-1];
            prod_reg  <= '0;
        end
        else if (busy_reg)
        begin
            prod_reg <= prod_reg + ((2*PROD_W)'(pp) << shamt);
        end
    end

    always_comb
    begin
        sat    = (|prod_reg[2*PROD_W-1:79]) || (prod_reg[78:16] > PROD_CAP);
        mag    = sat ? PROD_CAP : prod_reg[78:16];
        result = neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        done   = done_reg;
    end

endmodule

// File: hdl/gpg_ctrl.sv
// ----------------------------------------------------------------------------
// gpg_ctrl
// Sequencer: accepts a sample, steps the datapath through its products,
// the exponential lookup and the accumulate.
// ----------------------------------------------------------------------------
module gpg_ctrl
    import gpg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_ISSUE;
                    op_next    = OP_D2;
                end
            end
            ST_ISSUE: state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (sts.mul_done)
                begin
                    if (op_reg == OP_Y)
                        state_next = ST_EXP;
                    else if (op_reg == OP_C2)
                        state_next = ST_ACC;
                    else
                        state_next = ST_ISSUE;
                    op_next = next_op(op_reg);
                end
            end
            ST_EXP: state_next = ST_ISSUE;
            ST_ACC:
            begin
                if (!(sts.last && sts.out_full))
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.op        = op_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_ISSUE: cmd.mul_start = 1'b1;
            ST_WAIT:  cmd.wr_en     = sts.mul_done;
            ST_EXP:   cmd.exp_en    = 1'b1;
            ST_ACC:   cmd.acc_en    = !(sts.last && sts.out_full);
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_D2;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

endmodule

// File: hdl/gpg_datapath.sv
// ----------------------------------------------------------------------------
// gpg_datapath
// Registers, operand selection, shared multiplier, exp(-x) interpolation,
// saturating accumulators and the result register.
// ----------------------------------------------------------------------------
module gpg_datapath
    import gpg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    input  logic signed [DATA_W-1:0] sample_time,
    input  logic signed [DATA_W-1:0] time_gradient,
    input  logic                     last_sample,
    input  dp_cmd_t                  cmd,
    output dp_sts_t                  sts,
    input  logic                     out_ready,
    output logic                     out_valid,
    output logic signed [OUT_W-1:0]  grad_amplitude,
    output logic signed [OUT_W-1:0]  grad_width,
    output logic signed [OUT_W-1:0]  grad_center,
    output logic                     saturated
);

    localparam logic signed [SUM_W-1:0] ACC_MAX =
        {{(SUM_W-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] ACC_MIN = ~ACC_MAX;

    typedef struct packed {
        logic signed [ACC_WIDTH-1:0] value;
        logic                        ovf;
    } acc_res_t;

    function automatic acc_res_t acc_add(input logic signed [ACC_WIDTH-1:0] acc,
                                         input logic signed [PROD_W-1:0] term,
                                         input logic term_sat);
        acc_res_t             res;
        logic signed [SUM_W-1:0] s;
        s = SUM_W'(acc) + SUM_W'(term);
        res.ovf = 1'b1;
        if (term_sat)
            res.value = term[PROD_W-1] ? ACC_MIN[ACC_WIDTH-1:0] : ACC_MAX[ACC_WIDTH-1:0];
        else if (s > ACC_MAX)
            res.value = ACC_MAX[ACC_WIDTH-1:0];
        else if (s < ACC_MIN)
            res.value = ACC_MIN[ACC_WIDTH-1:0];
        else
        begin
            res.value = s[ACC_WIDTH-1:0];
            res.ovf   = 1'b0;
        end
        return res;
    endfunction

    function automatic logic [OUT_W-1:0] to_out(input logic signed [ACC_WIDTH-1:0] acc);
        logic signed [PROD_W-1:0] w;
        w = PROD_W'(acc);
        return w[OUT_W-1:0];
    endfunction

    // configuration
    logic signed [DATA_W-1:0] amp_reg, wid_reg, ctr_reg;

    // per-sample working registers
    logic signed [DATA_W-1:0] grad_reg;
    logic                     last_reg;
    logic signed [DATA_W:0]   d_reg;
    logic [48:0]              d2_reg;
    logic [46:0]              s2_reg;
    logic [PROD_W-2:0]        x_reg;
    logic [20:0]              y_reg;
    logic [EXP_W-1:0]         ex_reg;
    logic signed [DATA_W:0]   e_reg;
    logic signed [47:0]       p_reg;
    logic signed [PROD_W-1:0] w1_reg, tw_reg, c1_reg, tc_reg;
    logic                     w1_sat_reg, tw_sat_reg, c1_sat_reg, tc_sat_reg;

    // accumulators and result
    logic signed [ACC_WIDTH-1:0] sum_amp_reg, sum_wid_reg, sum_ctr_reg;
    logic                        ovf_reg;
    logic                        out_valid_reg;
    logic signed [OUT_W-1:0]     out_amp_reg, out_wid_reg, out_ctr_reg;
    logic                        out_sat_reg;

    logic signed [PROD_W-1:0] mul_a, mul_b, mul_res;
    logic                     mul_done, mul_sat;

    always_comb
    begin
        unique case (cmd.op)
            OP_D2:   begin mul_a = PROD_W'(d_reg);    mul_b = PROD_W'(d_reg);   end
            OP_S2:   begin mul_a = PROD_W'(wid_reg);  mul_b = PROD_W'(wid_reg); end
            OP_X:    begin mul_a = $signed(PROD_W'(s2_reg)); mul_b = $signed(PROD_W'(d2_reg)); end
            OP_Y:    begin mul_a = $signed({1'b0, x_reg}); mul_b = LOG2E_Q16; end
            OP_E:    begin mul_a = PROD_W'(grad_reg); mul_b = $signed(PROD_W'(ex_reg)); end
            OP_P:    begin mul_a = PROD_W'(e_reg);    mul_b = PROD_W'(amp_reg); end
            OP_W1:   begin mul_a = PROD_W'(p_reg);    mul_b = -(PROD_W'(wid_reg) <<< 1); end
            OP_W2:   begin mul_a = w1_reg;            mul_b = $signed(PROD_W'(d2_reg)); end
            OP_C1:   begin mul_a = PROD_W'(p_reg);    mul_b = $signed({16'd0, s2_reg, 1'b0}); end
            OP_C2:   begin mul_a = c1_reg;            mul_b = PROD_W'(d_reg); end
            default: begin mul_a = '0;                mul_b = '0; end
        endcase
    end

    gpg_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.mul_start),
        .op_a   (mul_a),
        .op_b   (mul_b),
        .done   (mul_done),
        .result (mul_res),
        .sat    (mul_sat)
    );

    // exp(-x) by table and linear interpolation, scaled by 2^-n
    logic [4:0]       tab_idx;
    logic [EXP_W-1:0] tab_lo, tab_hi, tab_v;
    logic [11:0]      tab_diff;
    logic [23:0]      interp;
    logic [EXP_W-1:0] ex_next;

    always_comb
    begin
        tab_idx  = {1'b0, y_reg[15:12]};
        tab_lo   = pow2_tab(tab_idx);
        tab_hi   = pow2_tab(tab_idx + 5'd1);
        tab_diff = 12'(tab_lo - tab_hi);
        interp   = 24'(tab_diff) * 24'(y_reg[11:0]);
        tab_v    = tab_lo - EXP_W'(interp[23:12]);
        if (x_reg >= EXP_LIMIT || y_reg[20:16] >= 5'd17)
            ex_next = '0;
        else
            ex_next = tab_v >> y_reg[20:16];
    end

    acc_res_t acc_a, acc_w, acc_c;

    always_comb
    begin
        acc_a = acc_add(sum_amp_reg, PROD_W'(e_reg), 1'b0);
        acc_w = acc_add(sum_wid_reg, tw_reg, tw_sat_reg);
        acc_c = acc_add(sum_ctr_reg, tc_reg, tc_sat_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_reg <= '0;
            wid_reg <= 32'sd65536;
            ctr_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_AMPLITUDE: amp_reg <= cfg_data;
                REG_WIDTH:     wid_reg <= cfg_data;
                REG_CENTER:    ctr_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            grad_reg <= time_gradient;
            last_reg <= last_sample;
            d_reg    <= (DATA_W+1)'(sample_time) - (DATA_W+1)'(ctr_reg);
        end
        if (cmd.exp_en)
            ex_reg <= ex_next;
        if (cmd.wr_en)
        begin
            case (cmd.op)
                OP_D2: d2_reg <= mul_res[48:0];
                OP_S2: s2_reg <= mul_res[46:0];
                OP_X:  x_reg  <= mul_res[PROD_W-2:0];
                OP_Y:  y_reg  <= mul_res[20:0];
                OP_E:  e_reg  <= mul_res[DATA_W:0];
                OP_P:  p_reg  <= mul_res[47:0];
                OP_W1:
                begin
                    w1_reg     <= mul_res;
                    w1_sat_reg <= mul_sat;
                end
                OP_W2:
                begin
                    tw_reg     <= mul_res;
                    tw_sat_reg <= mul_sat | w1_sat_reg;
                end
                OP_C1:
                begin
                    c1_reg     <= mul_res;
                    c1_sat_reg <= mul_sat;
                end
                OP_C2:
                begin
                    tc_reg     <= mul_res;
                    tc_sat_reg <= mul_sat | c1_sat_reg;
                end
                default: ;
            endcase
        end
        if (cmd.acc_en && last_reg)
        begin
            out_amp_reg <= to_out(acc_a.value);
            out_wid_reg <= to_out(acc_w.value);
            out_ctr_reg <= to_out(acc_c.value);
            out_sat_reg <= ovf_reg | acc_a.ovf | acc_w.ovf | acc_c.ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_amp_reg   <= '0;
            sum_wid_reg   <= '0;
            sum_ctr_reg   <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.acc_en)
            begin
                if (last_reg)
                begin
                    sum_amp_reg <= '0;
                    sum_wid_reg <= '0;
                    sum_ctr_reg <= '0;
                    ovf_reg     <= 1'b0;
                end
                else
                begin
                    sum_amp_reg <= acc_a.value;
                    sum_wid_reg <= acc_w.value;
                    sum_ctr_reg <= acc_c.value;
                    ovf_reg     <= ovf_reg | acc_a.ovf | acc_w.ovf | acc_c.ovf;
                end
            end
            if (cmd.acc_en && last_reg)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        sts.mul_done   = mul_done;
        sts.last       = last_reg;
        sts.out_full   = out_valid_reg && !out_ready;
        out_valid      = out_valid_reg;
        grad_amplitude = out_amp_reg;
        grad_width     = out_wid_reg;
        grad_center    = out_ctr_reg;
        saturated      = out_sat_reg;
    end

endmodule

// File: hdl/gaussian_pulse_param_gradient.sv
// A result is produced for the request carrying last_sample. A new sample is
// taken only after the last one is done: its ten products go in turn through the
// one shared 32x32 multiplier, plus lookup and accumulate steps.
// A finished result waits in its output register while the next sample is taken.
// Reset (rst_n, asynchronous, active low) clears the sums, the overflow flag and
// the registers to amplitude 0, width factor 1.0, centre 0.
// ----------------------------------------------------------------------------
// gaussian_pulse_param_gradient
// Top level: Gaussian pulse parameter gradient accumulator.
// ----------------------------------------------------------------------------
module gaussian_pulse_param_gradient
    import gpg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    gpg_in_if.sink               in_ch,
    gpg_out_if.source            out_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    gpg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gpg_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .sample_time    (in_ch.sample_time),
        .time_gradient  (in_ch.time_gradient),
        .last_sample    (in_ch.last_sample),
        .cmd            (cmd),
        .sts            (sts),
        .out_ready      (out_ch.ready),
        .out_valid      (out_ch.valid),
        .grad_amplitude (out_ch.grad_amplitude),
        .grad_width     (out_ch.grad_width),
        .grad_center    (out_ch.grad_center),
        .saturated      (out_ch.saturated)
    );

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !cmd.mul_start && !cmd.acc_en)
        else $error("sample taken while the datapath is busy");

    a_last_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc_en && sts.last |=> out_ch.valid)
        else $error("last sample gave no result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc_en && sts.last |-> !(out_ch.valid && !out_ch.ready))
        else $error("pending result overwritten");

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        sts.mul_done |-> !in_ch.ready)
        else $error("multiplier finished while idle");

endmodule

// File: bench/gpg_tb_if.sv
// ----------------------------------------------------------------------------
// gpg_tb_if
// Bench-side notes: the request channel interfaces come from the RTL (gpg_if).
// ----------------------------------------------------------------------------
package gpg_tb_pkg;
    import gpg_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample_time;
        logic signed [DATA_W-1:0] time_gradient;
        logic                     last_sample;
    } sample_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] grad_amplitude;
        logic signed [OUT_W-1:0] grad_width;
        logic signed [OUT_W-1:0] grad_center;
        logic                    saturated;
    } grad_t;
endpackage

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the Gaussian pulse gradient accumulator: samples are driven with
// random gaps, each is run through a fixed-point predictor, and every result
// is compared with the oldest predicted set of sums.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gpg_pkg::*;
    import gpg_tb_pkg::*;

    localparam longint ACC_HI = (64'sd1 <<< (ACC_WIDTH - 1)) - 1;
    localparam longint ACC_LO = -ACC_HI - 1;
    localparam longint CAP    = 64'sd1 <<< 62;
    localparam longint LIMIT  = 1000000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0] cfg_data;

    gpg_in_if  in_ch ();
    gpg_out_if out_ch ();

    gaussian_pulse_param_gradient DUT (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    longint amp_q, width_q, centre_q;
    longint sum_amp, sum_wid, sum_cen;
    bit     ovf_seen;
    grad_t  pending_grads[$];
    int     errors;
    longint cycles = 0;
    bit     quiet_out;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // exact Q16.16 product with clamp at 2^62
    function automatic longint q_mul(input longint x, input longint y, inout bit sat);
        logic [127:0] ux, uy, full, mag;
        bit neg;
        neg = (x < 0) != (y < 0);
        ux = (x < 0) ? 128'(-x) : 128'(x);
        uy = (y < 0) ? 128'(-y) : 128'(y);
        if (x == 64'h8000000000000000) ux = 128'h8000000000000000;
        if (y == 64'h8000000000000000) uy = 128'h8000000000000000;
        full = ux * uy;
        mag = full >> 16;
        if (mag > 128'(CAP))
        begin
            mag = 128'(CAP);
            sat = 1;
        end
        return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
    endfunction

    function automatic longint exp2_tab(input longint k);
        longint tab[17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
                            46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
        return tab[k];
    endfunction

    function automatic longint exp_neg_q(input longint x);
        bit dummy;
        longint y, v, n, idx, r;
        dummy = 0;
        if (x >= (longint'(12) <<< 16)) return 0;
        y = q_mul(x, 94548, dummy);
        n = y >>> 16;
        idx = (y & 16'hFFFF) >> 12;
        r = y & 12'hFFF;
        v = exp2_tab(idx) - (((exp2_tab(idx) - exp2_tab(idx + 1)) * r) >>> 12);
        if (n >= 17) return 0;
        return v >>> n;
    endfunction

    function automatic void add_term(ref longint acc, input longint term, input bit tsat);
        if (tsat)
        begin
            acc = (term < 0) ? ACC_LO : ACC_HI;
            ovf_seen = 1;
        end
        else if (term > 0 && acc > ACC_HI - term)
        begin
            acc = ACC_HI;
            ovf_seen = 1;
        end
        else if (term < 0 && acc < ACC_LO - term)
        begin
            acc = ACC_LO;
            ovf_seen = 1;
        end
        else
            acc += term;
    endfunction

    function automatic void predict_gradients(input sample_t s);
        bit ns, ws, cs;
        longint d, d2, s2, xq, e, p, tw, tc;
        grad_t g;
        ns = 0; ws = 0; cs = 0;
        d  = longint'(s.sample_time) - centre_q;
        d2 = q_mul(d, d, ns);
        s2 = q_mul(width_q, width_q, ns);
        xq = q_mul(s2, d2, ns);
        e  = q_mul(longint'(s.time_gradient), exp_neg_q(xq), ns);
        p  = q_mul(e, amp_q, ns);
        tw = q_mul(q_mul(p, -2 * width_q, ws), d2, ws);
        tc = q_mul(q_mul(p, 2 * s2, cs), d, cs);
        add_term(sum_amp, e, 0);
        add_term(sum_wid, tw, ws);
        add_term(sum_cen, tc, cs);
        if (s.last_sample)
        begin
            g.grad_amplitude = sum_amp[OUT_W-1:0];
            g.grad_width     = sum_wid[OUT_W-1:0];
            g.grad_center    = sum_cen[OUT_W-1:0];
            g.saturated      = ovf_seen;
            pending_grads.insert(pending_grads.size(), g);
            sum_amp = 0; sum_wid = 0; sum_cen = 0; ovf_seen = 0;
        end
    endfunction

    // result side: random stalls, compare at the rising edge
    initial
    begin
        int gap;
        out_ch.ready = 0;
        @(negedge clk);
        forever
        begin
            gap = quiet_out ? 0 : $urandom_range(0, 19);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap != 0)
            begin
                out_ch.ready <= 0;
                repeat (gap) @(negedge clk);
            end
            out_ch.ready <= 1;
            do @(posedge clk); while (!out_ch.valid);
            if (pending_grads.size() == 0)
            begin
                $display("%0t unexpected result exp none got %h", $time,
                         out_ch.grad_amplitude);
                errors++;
            end
            else
            begin
                grad_t x;
                x = pending_grads.pop_front();
                if (out_ch.grad_amplitude !== x.grad_amplitude)
                begin
                    $display("%0t grad_amplitude exp %h got %h", $time,
                             x.grad_amplitude, out_ch.grad_amplitude);
                    errors++;
                end
                if (out_ch.grad_width !== x.grad_width)
                begin
                    $display("%0t grad_width exp %h got %h", $time,
                             x.grad_width, out_ch.grad_width);
                    errors++;
                end
                if (out_ch.grad_center !== x.grad_center)
                begin
                    $display("%0t grad_center exp %h got %h", $time,
                             x.grad_center, out_ch.grad_center);
                    errors++;
                end
                if (out_ch.saturated !== x.saturated)
                begin
                    $display("%0t saturated exp %b got %b", $time,
                             x.saturated, out_ch.saturated);
                    errors++;
                end
            end
            @(negedge clk);
        end
    end

    // drop the request line once the last sample has been taken
    task automatic idle_input();
        @(negedge clk);
        in_ch.valid <= 0;
    endtask

    task automatic send_sample(input logic [31:0] t, input logic [31:0] g, input bit last);
        sample_t s;
        int gap;
        gap = $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0) gap = 0;
        @(negedge clk);
        if (gap != 0)
        begin
            in_ch.valid <= 0;
            repeat (gap) @(negedge clk);
        end
        s.sample_time = t; s.time_gradient = g; s.last_sample = last;
        in_ch.sample_time   <= t;
        in_ch.time_gradient <= g;
        in_ch.last_sample   <= last;
        in_ch.valid         <= 1;
        do @(posedge clk); while (!in_ch.ready);
        predict_gradients(s);
    endtask

    // only between runs, after every result has left
    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] v);
        idle_input();
        while (pending_grads.size() != 0) @(negedge clk);
        repeat (70) @(negedge clk);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
        @(negedge clk);
        cfg_we <= 0;
        case (idx)
            REG_AMPLITUDE: amp_q    = longint'($signed(v));
            REG_WIDTH:     width_q  = longint'($signed(v));
            default:       centre_q = longint'($signed(v));
        endcase
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0:       return 32'h7FFFFFFF;
            1:       return 32'h80000000;
            2:       return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
            default: return $urandom;
        endcase
    endfunction

    task automatic test_reset_values();
        send_sample(0, 32'h00010000, 1);
        send_sample(32'h00008000, 32'hFFFF0000, 0);
        send_sample(32'h00010000, 32'h00020000, 1);
    endtask

    task automatic test_field_extremes();
        write_reg(REG_AMPLITUDE, 32'h00018000);
        send_sample(32'h7FFFFFFF, 32'h7FFFFFFF, 0);
        send_sample(32'h80000000, 32'h80000000, 1);
        send_sample(32'h00004000, 32'h7FFFFFFF, 0);
        send_sample(32'hFFFFC000, 32'h80000000, 1);
        send_sample(32'h00000000, 32'hFFFFFFFF, 1);
    endtask

    task automatic test_saturation();
        write_reg(REG_AMPLITUDE, 32'h7FFFFFFF);
        write_reg(REG_WIDTH, 32'h00000100);
        for (int i = 0; i < 12; i++)
            send_sample(32'h7FFF0000, 32'h7FFFFFFF, i == 11);
        write_reg(REG_WIDTH, 32'h80000000);
        write_reg(REG_CENTER, 32'h80000000);
        send_sample(32'h80000000, 32'h80000000, 0);
        send_sample(32'h80000001, 32'h7FFFFFFF, 1);
    endtask

    task automatic test_random_runs(input int total);
        int sent, run_len;
        sent = 0;
        while (sent < total)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                write_reg(REG_AMPLITUDE, rand_word());
                write_reg(REG_WIDTH, rand_word());
                write_reg(REG_CENTER, rand_word());
            end
            quiet_out = ($urandom_range(0, 4) == 0);
            run_len = $urandom_range(1, 30);
            for (int i = 0; i < run_len; i++)
                send_sample(rand_word(), rand_word(), i == run_len - 1);
            sent += run_len;
        end
        quiet_out = 0;
    endtask

    initial
    begin
        errors = 0; quiet_out = 0;
        amp_q = 0; width_q = 65536; centre_q = 0;
        sum_amp = 0; sum_wid = 0; sum_cen = 0; ovf_seen = 0;
        rst_n = 0;
        cfg_we = 0; cfg_index = REG_AMPLITUDE; cfg_data = 0;
        in_ch.valid = 0; in_ch.sample_time = 0; in_ch.time_gradient = 0;
        in_ch.last_sample = 0;
        repeat (3) @(negedge clk);
        rst_n = 1;
        test_reset_values();
        test_field_extremes();
        test_saturation();
        write_reg(REG_WIDTH, 32'h00010000);
        write_reg(REG_CENTER, 32'h00000000);
        test_random_runs(1650);
        idle_input();
        while (pending_grads.size() != 0) @(negedge clk);
        repeat (80) @(negedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// File: gaussian_pulse_param_gradient.f
hdl/gpg_pkg.sv
hdl/gpg_if.sv
hdl/gpg_mul.sv
hdl/gpg_ctrl.sv
hdl/gpg_datapath.sv
hdl/gaussian_pulse_param_gradient.sv
bench/gpg_tb_if.sv
bench/tb.sv
